FILE: hdl/cis_pkg.sv
// Shared types, constants and byte folding for the substring search block.
package cis_pkg;

	localparam int unsigned NEEDLE_BYTES = 16;
	localparam int unsigned LEN_W        = 5;
	localparam int unsigned START_W      = 16;
	localparam int unsigned CFG_DATA_W   = 64;
	localparam int unsigned CFG_IDX_W    = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEEDLE_LOW  = 2'd0,
		CFG_NEEDLE_HIGH = 2'd1,
		CFG_NEEDLE_LEN  = 2'd2
	} cfg_index_t;

	// Input stage contents handed to the match logic.
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] upper;
	} s1_item_t;

	// Fold ASCII lower case letters to upper case; other bytes pass unchanged.
	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage

FILE: hdl/cis_ifs.sv
// Stream interfaces for haystack bytes and search results.
interface cis_text_if;
	import cis_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface cis_result_if;
	import cis_pkg::*;
	logic               valid;
	logic               ready;
	logic               match_found;
	logic [START_W-1:0] match_start;

	modport source (output valid, output match_found, output match_start, input ready);
	modport sink   (input valid, input match_found, input match_start, output ready);
endinterface

FILE: hdl/cis_in_stage.sv
// Input register: fold each accepted byte and hold it until the match stage takes it.
module cis_in_stage
	import cis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cis_text_if.sink    text,
	input  logic        out_free,
	output s1_item_t    item,
	output logic        fire
);

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] upper_s1;

	// A final byte may only leave once the result register can take it.
	assign fire       = valid_s1 && (!last_s1 || out_free);
	assign text.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			last_s1  <= text.final_byte;
			upper_s1 <= fold_upper(text.text_byte);
		end
	end

	assign item = '{valid: valid_s1, last: last_s1, upper: upper_s1};

endmodule

FILE: hdl/cis_matcher.sv
// Window of folded haystack bytes and the parallel compare against the needle.
module cis_matcher
	import cis_pkg::*;
#(
	parameter int unsigned MAX_NEEDLE = 16
) (
	input  logic                  clk,
	input  logic                  advance,
	input  logic [7:0]            upper,
	input  logic [CFG_DATA_W-1:0] needle_low,
	input  logic [CFG_DATA_W-1:0] needle_high,
	input  logic [LEN_W-1:0]      len,
	output logic                  all_eq
);

	localparam int unsigned WD = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;

	logic [7:0]                    window_q [WD];
	logic [7:0]                    cur      [MAX_NEEDLE];
	logic [2*CFG_DATA_W-1:0]       needle;
	logic [MAX_NEEDLE-1:0]         eq;

	assign needle = {needle_high, needle_low};

	// Entry 0 is the newest byte, the one being consumed now.
	always_comb begin
		cur[0] = upper;
		for (int j = 1; j < MAX_NEEDLE; j++) begin
			cur[j] = window_q[j-1];
		end
	end

	// Position j of the window lines up with needle byte len-1-j.
	always_comb begin
		logic [3:0] k;
		for (int j = 0; j < MAX_NEEDLE; j++) begin
			k = 4'(len - LEN_W'(j) - 1'b1);
			eq[j] = (LEN_W'(j) >= len) || (cur[j] == fold_upper(needle[k*8 +: 8]));
		end
	end

	assign all_eq = &eq;

	// Advance the window by one byte.
	always_ff @(posedge clk) begin
		if (advance) begin
			window_q[0] <= upper;
			for (int j = 1; j < WD; j++) begin
				window_q[j] <= window_q[j-1];
			end
		end
	end

endmodule

FILE: hdl/case_insensitive_substring_search.sv
// Case-insensitive substring search over a byte stream.
// Haystack bytes arrive one per transfer on the text channel; each byte is folded to upper case
// (ASCII a to z only) and compared, together with the newest preceding bytes, against the folded
// needle held in the configuration registers (needle bytes 0 to 7 at index 0, bytes 8 to 15 at
// index 1, length 0 to 16 at index 2). The first match start is kept; on the byte marked final
// one result transfer reports match_found and match_start (0 when nothing was found) and the
// stream state is cleared for the next haystack. An empty needle matches at 0, a needle longer
// than the haystack or than MAX_NEEDLE is never found, and once MAX_TEXT bytes have been counted
// later matches are ignored. Throughput is one byte per clock: each byte is held in the
// input register, where the window compare and state update run in a single step, and the
// result register holds a finished result while further bytes keep flowing. A final byte waits
// in the input register only while an earlier result is still untaken, and its result is
// then captured in the result register. Write the configuration only while idle.
module case_insensitive_substring_search
	import cis_pkg::*;
#(
	parameter int unsigned MAX_NEEDLE = 16,
	parameter int unsigned MAX_TEXT   = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cis_text_if.sink              text,
	cis_result_if.source          result,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned PW = $clog2(MAX_TEXT + 1);

	// Configuration registers.
	logic [CFG_DATA_W-1:0] needle_low_q;
	logic [CFG_DATA_W-1:0] needle_high_q;
	logic [LEN_W-1:0]      needle_len_q;

	// Stream state.
	logic [PW-1:0]      pos_q;
	logic               found_q;
	logic [START_W-1:0] start_q;

	// Result register.
	logic               res_valid_q;
	logic               res_found_q;
	logic [START_W-1:0] res_start_q;

	s1_item_t           item;
	logic               fire;
	logic               out_free;
	logic               all_eq;

	logic [PW-1:0]      count;
	logic               counting;
	logic               hit;
	logic [31:0]        diff;
	logic               found_nx;
	logic [START_W-1:0] start_nx;

	assign out_free = !res_valid_q || result.ready;

	cis_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.out_free (out_free),
		.item     (item),
		.fire     (fire)
	);

	cis_matcher #(
		.MAX_NEEDLE (MAX_NEEDLE)
	) u_match (
		.clk         (clk),
		.advance     (fire),
		.upper       (item.upper),
		.needle_low  (needle_low_q),
		.needle_high (needle_high_q),
		.len         (needle_len_q),
		.all_eq      (all_eq)
	);

	// Configuration writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q  <= '0;
			needle_high_q <= '0;
			needle_len_q  <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_NEEDLE_LOW:  needle_low_q  <= cfg_wdata;
				CFG_NEEDLE_HIGH: needle_high_q <= cfg_wdata;
				CFG_NEEDLE_LEN:  needle_len_q  <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Match decision for the byte now leaving the input register.
	always_comb begin
		counting = (pos_q < PW'(MAX_TEXT));
		count    = pos_q + 1'b1;
		diff     = 32'(count) - 32'(needle_len_q);
		hit      = (needle_len_q == '0) ||
			((needle_len_q <= LEN_W'(MAX_NEEDLE)) && (count >= PW'(needle_len_q)) && all_eq);
		found_nx = found_q;
		start_nx = start_q;
		if (counting && !found_q && hit) begin
			found_nx = 1'b1;
			// Empty needle is forced to zero here, since count minus zero would be count, not zero.
			start_nx = (needle_len_q == '0) ? '0 : diff[START_W-1:0];
		end
	end

	// Advance the stream state; clear it after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			found_q <= 1'b0;
			start_q <= '0;
		end else if (fire) begin
			if (item.last) begin
				pos_q   <= '0;
				found_q <= 1'b0;
				start_q <= '0;
			end else begin
				if (counting) begin
					pos_q <= count;
				end
				found_q <= found_nx;
				start_q <= start_nx;
			end
		end
	end

	// Hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && item.last) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item.last) begin
			res_found_q <= found_nx;
			res_start_q <= found_nx ? start_nx : '0;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.match_found = res_found_q;
	assign result.match_start = res_start_q;

endmodule
